// ===== sv/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg: shared definitions for the frustum cull tester
// Field widths, plane register packing, test kinds and chain control struct.
// ----------------------------------------------------------------------------
package fct_pkg;

   // Plane register packing
   localparam int PLANE_BITS     = 64;
   localparam int NORMAL_BITS    = 14;
   localparam int NORMAL_FRAC    = 12;
   localparam int OFFSET_BITS    = 22;
   localparam int NX_LSB         = 0;
   localparam int NY_LSB         = 14;
   localparam int NZ_LSB         = 28;
   localparam int OFFSET_LSB     = 42;

   // Item fields
   localparam int FUNC_BITS      = 2;
   localparam int HALF_BITS      = 15;

   // Configuration port
   localparam int MAX_PLANES     = 6;
   localparam int CSR_INDEX_BITS = 3;

   // Parameter defaults
   localparam int DEFAULT_NUM_PLANES = 6;
   localparam int DEFAULT_COORD_BITS = 16;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_POINT  = 2'd0,
      FUNC_CUBE   = 2'd1,
      FUNC_SPHERE = 2'd2,
      FUNC_BOX    = 2'd3
   } func_type;

   // Control word that travels along the cell chain with each object
   typedef struct packed {
      logic valid;
      logic visible;
   } ctrl_type;

endpackage

// ===== sv/fct_cell.sv =====
// ----------------------------------------------------------------------------
// fct_cell: one plane test cell of the cull chain
// Picks the corner farthest along the plane normal, forms the scaled
// distance over two register stages and clears the visible flag on a cull.
// ----------------------------------------------------------------------------
module fct_cell
   import fct_pkg::*;
#(
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [PLANE_BITS-1:0]        plane,
   input  ctrl_type                     in_ctrl,
   input  logic signed [COORD_BITS-1:0] in_cx,
   input  logic signed [COORD_BITS-1:0] in_cy,
   input  logic signed [COORD_BITS-1:0] in_cz,
   input  logic [HALF_BITS-1:0]         in_hx,
   input  logic [HALF_BITS-1:0]         in_hy,
   input  logic [HALF_BITS-1:0]         in_hz,
   input  logic [HALF_BITS-1:0]         in_rs,
   output ctrl_type                     out_ctrl,
   output logic signed [COORD_BITS-1:0] out_cx,
   output logic signed [COORD_BITS-1:0] out_cy,
   output logic signed [COORD_BITS-1:0] out_cz,
   output logic [HALF_BITS-1:0]         out_hx,
   output logic [HALF_BITS-1:0]         out_hy,
   output logic [HALF_BITS-1:0]         out_hz,
   output logic [HALF_BITS-1:0]         out_rs
);

   // Corner, product, offset and sum widths
   localparam int CW = ((COORD_BITS > HALF_BITS + 1) ? COORD_BITS : HALF_BITS + 1) + 1;
   localparam int PW = NORMAL_BITS + CW;
   localparam int OW = OFFSET_BITS + 1;
   localparam int SW = ((PW > OW + NORMAL_FRAC) ? PW : OW + NORMAL_FRAC) + 2;

   // Unpack the plane
   logic signed [NORMAL_BITS-1:0] nx, ny, nz;
   logic signed [OFFSET_BITS-1:0] d;

   assign nx = signed'(plane[NX_LSB +: NORMAL_BITS]);
   assign ny = signed'(plane[NY_LSB +: NORMAL_BITS]);
   assign nz = signed'(plane[NZ_LSB +: NORMAL_BITS]);
   assign d  = signed'(plane[OFFSET_LSB +: OFFSET_BITS]);

   // Stage A: far corner and products
   logic signed [CW-1:0] corner_x, corner_y, corner_z;
   logic signed [PW-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [PW-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [OW-1:0] offset_in, offset_ff;
   ctrl_type             ctrl_a_ff;

   logic signed [COORD_BITS-1:0] cx_a_ff, cy_a_ff, cz_a_ff;
   logic [HALF_BITS-1:0]         hx_a_ff, hy_a_ff, hz_a_ff, rs_a_ff;

   always_comb begin
      corner_x = nx[NORMAL_BITS-1] ? CW'(in_cx) - signed'(CW'(in_hx))
                                   : CW'(in_cx) + signed'(CW'(in_hx));
      corner_y = ny[NORMAL_BITS-1] ? CW'(in_cy) - signed'(CW'(in_hy))
                                   : CW'(in_cy) + signed'(CW'(in_hy));
      corner_z = nz[NORMAL_BITS-1] ? CW'(in_cz) - signed'(CW'(in_hz))
                                   : CW'(in_cz) + signed'(CW'(in_hz));
      prod_x_in = PW'(nx) * PW'(corner_x);
      prod_y_in = PW'(ny) * PW'(corner_y);
      prod_z_in = PW'(nz) * PW'(corner_z);
      // Sphere slack folds into the plane offset
      offset_in = OW'(d) + signed'(OW'(in_rs));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
      end else begin
         ctrl_a_ff <= in_ctrl;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      offset_ff <= offset_in;
      cx_a_ff   <= in_cx;
      cy_a_ff   <= in_cy;
      cz_a_ff   <= in_cz;
      hx_a_ff   <= in_hx;
      hy_a_ff   <= in_hy;
      hz_a_ff   <= in_hz;
      rs_a_ff   <= in_rs;
   end

   // Stage B: sum and sign test
   logic signed [SW-1:0] plane_dist;
   ctrl_type             ctrl_b_in, ctrl_b_ff;

   always_comb begin
      plane_dist = SW'(prod_x_ff) + SW'(prod_y_ff) + SW'(prod_z_ff)
                 + (SW'(offset_ff) <<< NORMAL_FRAC);
      ctrl_b_in         = ctrl_a_ff;
      ctrl_b_in.visible = ctrl_a_ff.visible & ~plane_dist[SW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_b_ff <= '0;
      end else begin
         ctrl_b_ff <= ctrl_b_in;
      end
      out_cx <= cx_a_ff;
      out_cy <= cy_a_ff;
      out_cz <= cz_a_ff;
      out_hx <= hx_a_ff;
      out_hy <= hy_a_ff;
      out_hz <= hz_a_ff;
      out_rs <= rs_a_ff;
   end

   assign out_ctrl = ctrl_b_ff;

   // Checks
   a_valid_flows : assert property (@(posedge clock) disable iff (reset)
      in_ctrl.valid |-> ##2 out_ctrl.valid)
      else $error("fct_cell: object lost in cell");

   a_no_invent : assert property (@(posedge clock) disable iff (reset)
      out_ctrl.valid |-> $past(in_ctrl.valid, 2))
      else $error("fct_cell: object appeared without a transfer");

   a_only_clears : assert property (@(posedge clock) disable iff (reset)
      (out_ctrl.valid && out_ctrl.visible) |-> $past(in_ctrl.visible, 2))
      else $error("fct_cell: visible flag set by a cell");

   a_zero_plane : assert property (@(posedge clock) disable iff (reset)
      (in_ctrl.valid && in_ctrl.visible && plane == '0) |-> ##2 out_ctrl.visible)
      else $error("fct_cell: all-zero plane culled an object");

endmodule

// ===== sv/frustum_cull_tester_unit.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_tester_unit: six-plane view frustum cull tester
// Tests one object a cycle against the configured planes in a chain of
// plane cells and strobes out a single visible flag per object.
// ----------------------------------------------------------------------------
// Pipeline: one setup stage, then two stages in each plane cell.
// Throughput: one object per cycle; busy is always low.
// Results cannot be stalled: each strobe lasts exactly one cycle.
// Reset (synchronous): empties the chain and clears all plane registers to
//   zero, and an all-zero plane never culls.
module frustum_cull_tester_unit
   import fct_pkg::*;
#(
   parameter int NUM_PLANES = DEFAULT_NUM_PLANES,
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // Object requests
   input  logic                         start,
   output logic                         busy,
   input  logic [FUNC_BITS-1:0]         req_func,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic signed [COORD_BITS-1:0] req_center_z,
   input  logic [HALF_BITS-1:0]         req_radius,
   input  logic [HALF_BITS-1:0]         req_half_x,
   input  logic [HALF_BITS-1:0]         req_half_y,
   input  logic [HALF_BITS-1:0]         req_half_z,
   // Results
   output logic                         strobe,
   output logic                         rsp_visible,
   // Plane registers
   input  logic                         csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [PLANE_BITS-1:0]        csr_wdata
);

   // Never stall the request side
   assign busy = 1'b0;

   // Plane registers
   logic [PLANE_BITS-1:0] plane_in [NUM_PLANES];
   logic [PLANE_BITS-1:0] plane_ff [NUM_PLANES];

   always_comb begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         plane_in[i] = plane_ff[i];
         if (csr_wr_en && csr_index == CSR_INDEX_BITS'(i)) begin
            plane_in[i] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
         if (reset) begin
            plane_ff[i] <= '0;
         end else begin
            plane_ff[i] <= plane_in[i];
         end
      end
   end

   // Setup stage: pick half extents and sphere slack by test kind
   ctrl_type                     prep_ctrl_in, prep_ctrl_ff;
   logic [HALF_BITS-1:0]         hx_in, hy_in, hz_in, rs_in;
   logic [HALF_BITS-1:0]         hx_ff, hy_ff, hz_ff, rs_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;

   always_comb begin
      prep_ctrl_in.valid   = start && !busy;
      prep_ctrl_in.visible = 1'b1;
      hx_in = '0;
      hy_in = '0;
      hz_in = '0;
      rs_in = '0;
      case (func_type'(req_func))
         FUNC_POINT: begin
         end
         FUNC_CUBE: begin
            hx_in = req_radius;
            hy_in = req_radius;
            hz_in = req_radius;
         end
         FUNC_SPHERE: begin
            rs_in = req_radius;
         end
         FUNC_BOX: begin
            hx_in = req_half_x;
            hy_in = req_half_y;
            hz_in = req_half_z;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctrl_ff <= '0;
      end else begin
         prep_ctrl_ff <= prep_ctrl_in;
      end
      cx_ff <= req_center_x;
      cy_ff <= req_center_y;
      cz_ff <= req_center_z;
      hx_ff <= hx_in;
      hy_ff <= hy_in;
      hz_ff <= hz_in;
      rs_ff <= rs_in;
   end

   // Cell chain, one cell per plane
   ctrl_type                     ctrl_chain [NUM_PLANES+1];
   logic signed [COORD_BITS-1:0] cx_chain   [NUM_PLANES+1];
   logic signed [COORD_BITS-1:0] cy_chain   [NUM_PLANES+1];
   logic signed [COORD_BITS-1:0] cz_chain   [NUM_PLANES+1];
   logic [HALF_BITS-1:0]         hx_chain   [NUM_PLANES+1];
   logic [HALF_BITS-1:0]         hy_chain   [NUM_PLANES+1];
   logic [HALF_BITS-1:0]         hz_chain   [NUM_PLANES+1];
   logic [HALF_BITS-1:0]         rs_chain   [NUM_PLANES+1];

   assign ctrl_chain[0] = prep_ctrl_ff;
   assign cx_chain[0]   = cx_ff;
   assign cy_chain[0]   = cy_ff;
   assign cz_chain[0]   = cz_ff;
   assign hx_chain[0]   = hx_ff;
   assign hy_chain[0]   = hy_ff;
   assign hz_chain[0]   = hz_ff;
   assign rs_chain[0]   = rs_ff;

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      fct_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .plane    (plane_ff[g]),
         .in_ctrl  (ctrl_chain[g]),
         .in_cx    (cx_chain[g]),
         .in_cy    (cy_chain[g]),
         .in_cz    (cz_chain[g]),
         .in_hx    (hx_chain[g]),
         .in_hy    (hy_chain[g]),
         .in_hz    (hz_chain[g]),
         .in_rs    (rs_chain[g]),
         .out_ctrl (ctrl_chain[g+1]),
         .out_cx   (cx_chain[g+1]),
         .out_cy   (cy_chain[g+1]),
         .out_cz   (cz_chain[g+1]),
         .out_hx   (hx_chain[g+1]),
         .out_hy   (hy_chain[g+1]),
         .out_hz   (hz_chain[g+1]),
         .out_rs   (rs_chain[g+1])
      );
   end

   // Drive the result from the last cell's registers
   assign strobe      = ctrl_chain[NUM_PLANES].valid;
   assign rsp_visible = ctrl_chain[NUM_PLANES].visible;

endmodule

// ===== tb/tb_frustum_cull_tester_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_cull_tester_unit: self-checking bench for the frustum cull tester
// Streams point, cube, sphere and box objects through the block under a series
// of plane settings. Each visible flag is predicted from exact integer plane
// distances and checked in order against the strobed results.
// ----------------------------------------------------------------------------
module tb_frustum_cull_tester_unit;
   import fct_pkg::*;

   localparam int NUM_PLANES    = DEFAULT_NUM_PLANES;
   localparam int COORD_BITS    = DEFAULT_COORD_BITS;
   localparam int LATENCY       = 2*NUM_PLANES + 1;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_OBJECTS = 140;
   localparam int NORMAL_MIN    = -(1 << (NORMAL_BITS-1));
   localparam int NORMAL_MAX    = (1 << (NORMAL_BITS-1)) - 1;
   localparam int OFFSET_MIN    = -(1 << (OFFSET_BITS-1));
   localparam int OFFSET_MAX    = (1 << (OFFSET_BITS-1)) - 1;
   localparam int UNIT_NORMAL   = 1 << NORMAL_FRAC;

   typedef enum int {
      PLANE_NEAR, PLANE_FAR, PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM
   } plane_sel_type;

   typedef enum int {
      SET_RAW, SET_EXTREME, SET_SHAPED
   } plane_style_type;

   typedef struct {
      func_type                     func;
      logic signed [COORD_BITS-1:0] cx, cy, cz;
      logic [HALF_BITS-1:0]         radius, hx, hy, hz;
   } cull_item_type;

   // Plane copy, predicted visible flags and result bookkeeping
   class visibility_scoreboard;
      logic [PLANE_BITS-1:0] plane [MAX_PLANES];
      bit                    pending_vis [$];
      int                    errors, n_visible, n_culled;

      function new();
         foreach (plane[i]) plane[i] = '0;
         errors = 0; n_visible = 0; n_culled = 0;
      endfunction

      function void set_plane(int index, logic [PLANE_BITS-1:0] value);
         // drop writes past the last plane register
         if (index < MAX_PLANES) plane[index] = value;
      endfunction

      function bit predict_visible(cull_item_type obj);
         longint cx, cy, cz, hx, hy, hz, limit;
         longint nx, ny, nz, ofs, px, py, pz, plane_dist;
         bit     vis;
         cx = obj.cx; cy = obj.cy; cz = obj.cz;
         hx = 0; hy = 0; hz = 0; limit = 0;
         vis = 1'b1;
         case (obj.func)
            FUNC_CUBE: begin
               hx = obj.radius; hy = obj.radius; hz = obj.radius;
            end
            FUNC_BOX: begin
               hx = obj.hx; hy = obj.hy; hz = obj.hz;
            end
            FUNC_SPHERE: limit = -(longint'(obj.radius) <<< NORMAL_FRAC);
            default: ;
         endcase
         // test the corner farthest along each normal, scaled by 4096
         for (int i = 0; i < NUM_PLANES; i++) begin
            nx  = $signed(plane[i][NX_LSB +: NORMAL_BITS]);
            ny  = $signed(plane[i][NY_LSB +: NORMAL_BITS]);
            nz  = $signed(plane[i][NZ_LSB +: NORMAL_BITS]);
            ofs = $signed(plane[i][OFFSET_LSB +: OFFSET_BITS]);
            px  = (nx >= 0) ? cx + hx : cx - hx;
            py  = (ny >= 0) ? cy + hy : cy - hy;
            pz  = (nz >= 0) ? cz + hz : cz - hz;
            plane_dist = nx*px + ny*py + nz*pz + (ofs <<< NORMAL_FRAC);
            if (plane_dist < limit) vis = 1'b0;
         end
         return vis;
      endfunction

      function void note_object(cull_item_type obj);
         pending_vis.push_back(predict_visible(obj));
      endfunction

      function void check_result(logic vis);
         bit want;
         if (pending_vis.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual visible=%0b",
                     $time, vis);
            errors++;
            return;
         end
         want = pending_vis.pop_front();
         if (vis !== want) begin
            $display("%0t: visible mismatch, expected %0b, actual %0b",
                     $time, want, vis);
            errors++;
         end
         if (want) n_visible++;
         else n_culled++;
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [FUNC_BITS-1:0]         req_func = '0;
   logic signed [COORD_BITS-1:0] req_center_x = '0;
   logic signed [COORD_BITS-1:0] req_center_y = '0;
   logic signed [COORD_BITS-1:0] req_center_z = '0;
   logic [HALF_BITS-1:0]         req_radius = '0;
   logic [HALF_BITS-1:0]         req_half_x = '0;
   logic [HALF_BITS-1:0]         req_half_y = '0;
   logic [HALF_BITS-1:0]         req_half_z = '0;
   logic                         strobe;
   logic                         rsp_visible;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [PLANE_BITS-1:0]        csr_wdata = '0;

   visibility_scoreboard sb = new();
   logic [PLANE_BITS-1:0] plane_set [MAX_PLANES];
   int accepted = 0;
   int burst_left = 0;
   int plane_settings = 0;

   frustum_cull_tester_unit #(
      .NUM_PLANES(NUM_PLANES),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .req_half_x   (req_half_x),
      .req_half_y   (req_half_y),
      .req_half_z   (req_half_z),
      .strobe       (strobe),
      .rsp_visible  (rsp_visible),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // Check strobed results and note each object transfer at the rising edge
   always @(posedge clock) begin
      cull_item_type seen;
      if (!reset) begin
         if (strobe) sb.check_result(rsp_visible);
         if (start && !busy) begin
            seen.func   = func_type'(req_func);
            seen.cx     = req_center_x;
            seen.cy     = req_center_y;
            seen.cz     = req_center_z;
            seen.radius = req_radius;
            seen.hx     = req_half_x;
            seen.hy     = req_half_y;
            seen.hz     = req_half_z;
            sb.note_object(seen);
            accepted++;
         end
      end
   end

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic logic [PLANE_BITS-1:0] pack_plane(int nx, int ny, int nz, int ofs);
      logic [PLANE_BITS-1:0] p;
      p = '0;
      p[NX_LSB +: NORMAL_BITS]     = nx[NORMAL_BITS-1:0];
      p[NY_LSB +: NORMAL_BITS]     = ny[NORMAL_BITS-1:0];
      p[NZ_LSB +: NORMAL_BITS]     = nz[NORMAL_BITS-1:0];
      p[OFFSET_LSB +: OFFSET_BITS] = ofs[OFFSET_BITS-1:0];
      return p;
   endfunction

   function automatic int pick_extreme(int lo, int hi);
      case ($urandom_range(2, 0))
         0: return lo;
         1: return hi;
         default: return 0;
      endcase
   endfunction

   function automatic cull_item_type make_object(func_type func, int cx, int cy, int cz,
                                                 int r, int hx, int hy, int hz);
      cull_item_type obj;
      obj.func = func;
      obj.cx = cx[COORD_BITS-1:0]; obj.cy = cy[COORD_BITS-1:0]; obj.cz = cz[COORD_BITS-1:0];
      obj.radius = r[HALF_BITS-1:0];
      obj.hx = hx[HALF_BITS-1:0]; obj.hy = hy[HALF_BITS-1:0]; obj.hz = hz[HALF_BITS-1:0];
      return obj;
   endfunction

   // Full-range fields now and then, otherwise objects near the frustum
   function automatic cull_item_type random_object();
      bit wide;
      wide = ($urandom_range(3, 0) == 0);
      if (wide)
         return make_object(func_type'($urandom_range(3, 0)), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      return make_object(func_type'($urandom_range(3, 0)),
                         rand_between(-6000, 6000), rand_between(-6000, 6000),
                         rand_between(-6000, 6000), $urandom_range(2500, 0),
                         $urandom_range(2500, 0), $urandom_range(2500, 0),
                         $urandom_range(2500, 0));
   endfunction

   // Fill plane_set in one of three styles
   task automatic build_planes(plane_style_type style);
      for (int i = 0; i < MAX_PLANES; i++) begin
         case (style)
            SET_RAW: plane_set[i] = {$urandom(), $urandom()};
            SET_EXTREME: plane_set[i] = pack_plane(pick_extreme(NORMAL_MIN, NORMAL_MAX),
                                                   pick_extreme(NORMAL_MIN, NORMAL_MAX),
                                                   pick_extreme(NORMAL_MIN, NORMAL_MAX),
                                                   pick_extreme(OFFSET_MIN, OFFSET_MAX));
            default: begin
               // keep the origin mostly inside, with some planes left unused
               if ($urandom_range(5, 0) == 0) plane_set[i] = '0;
               else plane_set[i] = pack_plane(rand_between(NORMAL_MIN, NORMAL_MAX),
                                              rand_between(NORMAL_MIN, NORMAL_MAX),
                                              rand_between(NORMAL_MIN, NORMAL_MAX),
                                              rand_between(-400, 3000));
            end
         endcase
      end
   endtask

   // Write all plane registers, optionally also the unused indexes
   task automatic load_planes(bit with_stray);
      for (int i = 0; i < (with_stray ? (1 << CSR_INDEX_BITS) : MAX_PLANES); i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[CSR_INDEX_BITS-1:0];
         csr_wdata <= (i < MAX_PLANES) ? plane_set[i] : {$urandom(), $urandom()};
         @(negedge clock);
         if (i < MAX_PLANES) sb.set_plane(i, plane_set[i]);
      end
      csr_wr_en <= 1'b0;
      plane_settings++;
   endtask

   // Present one object and hold it until its transfer; returns at a falling edge
   task automatic send_object(cull_item_type obj);
      int target;
      target = accepted + 1;
      start        <= 1'b1;
      req_func     <= obj.func;
      req_center_x <= obj.cx;
      req_center_y <= obj.cy;
      req_center_z <= obj.cz;
      req_radius   <= obj.radius;
      req_half_x   <= obj.hx;
      req_half_y   <= obj.hy;
      req_half_z   <= obj.hz;
      do @(negedge clock); while (accepted < target);
   endtask

   // Send in bursts, with a random gap after each burst when gaps are on
   task automatic send_paced(cull_item_type obj, bit gaps);
      int gap;
      send_object(obj);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(24, 1);
         gap = gaps ? $urandom_range(8, 1) : 0;
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Hold off the sender until every predicted flag has come back
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_vis.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset planes are all zero: nothing may be culled
      send_object(make_object(FUNC_POINT, -32768, -32768, -32768, 32767, 0, 0, 0));
      send_object(make_object(FUNC_CUBE, 32767, 32767, 32767, 32767, 0, 0, 0));
      send_object(make_object(FUNC_SPHERE, -32768, -32768, -32768, 32767, 0, 0, 0));
      send_object(make_object(FUNC_BOX, -32768, -32768, -32768, 0, 32767, 32767, 32767));
      send_object(make_object(FUNC_BOX, 32767, 32767, 32767, 32767, 0, 0, 0));
      drain();

      // Near plane only, z >= 100: boundaries of each mode, unused fields loaded
      foreach (plane_set[i]) plane_set[i] = '0;
      plane_set[PLANE_NEAR] = pack_plane(0, 0, UNIT_NORMAL, -100);
      load_planes(1'b0);
      send_object(make_object(FUNC_POINT, 0, 0, 100, 32767, 32767, 32767, 32767));
      send_object(make_object(FUNC_POINT, 0, 0, 99, 0, 0, 0, 0));
      send_object(make_object(FUNC_SPHERE, 5, -5, 90, 10, 32767, 32767, 32767));
      send_object(make_object(FUNC_SPHERE, 5, -5, 89, 10, 0, 0, 0));
      send_object(make_object(FUNC_CUBE, -7, 7, 90, 10, 32767, 32767, 32767));
      send_object(make_object(FUNC_CUBE, -7, 7, 89, 10, 0, 0, 0));
      send_object(make_object(FUNC_BOX, 0, 0, 95, 32767, 1, 2, 5));
      send_object(make_object(FUNC_BOX, 0, 0, 94, 32767, 1, 2, 5));
      send_object(make_object(FUNC_BOX, 0, 0, 100, 0, 0, 0, 0));
      drain();

      // Extreme normals and offsets, plus writes to the unused indexes
      plane_set[PLANE_NEAR]   = pack_plane(NORMAL_MIN, NORMAL_MAX, NORMAL_MIN, OFFSET_MIN);
      plane_set[PLANE_FAR]    = pack_plane(NORMAL_MAX, NORMAL_MIN, NORMAL_MAX, OFFSET_MAX);
      plane_set[PLANE_LEFT]   = pack_plane(NORMAL_MIN, 0, 0, OFFSET_MAX);
      plane_set[PLANE_RIGHT]  = pack_plane(0, NORMAL_MAX, 0, OFFSET_MAX);
      plane_set[PLANE_TOP]    = pack_plane(0, 0, NORMAL_MIN, OFFSET_MAX);
      plane_set[PLANE_BOTTOM] = pack_plane(NORMAL_MAX, NORMAL_MAX, NORMAL_MAX, OFFSET_MAX);
      load_planes(1'b1);
      send_object(make_object(FUNC_POINT, -32768, 32767, -32768, 0, 0, 0, 0));
      send_object(make_object(FUNC_SPHERE, 0, 0, 0, 32767, 0, 0, 0));
      send_object(make_object(FUNC_CUBE, 32767, -32768, 32767, 32767, 0, 0, 0));
      send_object(make_object(FUNC_BOX, -32768, -32768, -32768, 0, 32767, 32767, 32767));
      send_object(make_object(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));

      // Random phases, each under a fresh plane setting
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         drain();
         build_planes(k == 0 ? SET_RAW : (k == 1 ? SET_EXTREME : SET_SHAPED));
         load_planes(k % 2);
         for (int n = 0; n < PHASE_OBJECTS; n++)
            send_paced(random_object(), (k % 3) != 2);
      end

      drain();
      repeat (LATENCY + 4) @(negedge clock);
      $display("Run covered %0d objects in all four test kinds under %0d plane settings.",
               accepted, plane_settings);
      $display("Flags checked: %0d visible, %0d culled, %0d mismatches.",
               sb.n_visible, sb.n_culled, sb.errors);
      if (sb.errors == 0 && sb.pending_vis.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog
   initial begin
      #200_000;
      $display("simulation failed");
      $finish;
   end

endmodule
